### rtl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define ASSERT_CHK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	`ASSERT_CHK(lbl, clk, rst_n, !(cond), msg)

`endif

### rtl/bpe_pkg.sv
`default_nettype none
package bpe_pkg;

	localparam int TOK_W = 11;
	localparam int BYTE_W = 8;
	localparam int SLOT_W = 10;
	localparam int CFG_W = 11;
	localparam int REQ_W = 2;
	localparam int NUM_CELLS = 8;
	localparam int CELL_W = $clog2(NUM_CELLS);
	localparam int DEFAULT_MAX_RULES = 1024;
	localparam int S_DATA_W = 56;
	localparam int M_DATA_W = 16;

	localparam logic [REQ_W-1:0] REQ_LOAD = 2'd0;
	localparam logic [REQ_W-1:0] REQ_TEXT = 2'd1;
	localparam logic [REQ_W-1:0] REQ_DRAIN = 2'd2;

	typedef logic [TOK_W-1:0] tok_t;

	typedef struct packed {
		logic vld;
		logic search;
		tok_t tok;
	} chain_msg_t;

	typedef struct packed {
		logic vld;
		logic res;
		logic eos;
		tok_t tok;
	} fin_t;

	typedef struct packed {
		tok_t left;
		tok_t right;
		tok_t merged;
	} rule_t;

endpackage
`default_nettype wire

### rtl/bpe_cell.sv
`default_nettype none
module bpe_cell import bpe_pkg::*; #(
	parameter int MAX_RULES = DEFAULT_MAX_RULES
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic [$clog2((((MAX_RULES + NUM_CELLS - 1) / NUM_CELLS) > 1) ?
		((MAX_RULES + NUM_CELLS - 1) / NUM_CELLS) : 2) + CELL_W : 0] n,
	input  wire chain_msg_t in_msg,
	input  wire logic [$clog2((((MAX_RULES + NUM_CELLS - 1) / NUM_CELLS) > 1) ?
		((MAX_RULES + NUM_CELLS - 1) / NUM_CELLS) : 2) + CELL_W : 0] in_idx,
	output chain_msg_t out_msg,
	output logic [$clog2((((MAX_RULES + NUM_CELLS - 1) / NUM_CELLS) > 1) ?
		((MAX_RULES + NUM_CELLS - 1) / NUM_CELLS) : 2) + CELL_W : 0] out_idx,
	output fin_t fin,
	input  wire logic clr_en,
	input  wire logic [$clog2((((MAX_RULES + NUM_CELLS - 1) / NUM_CELLS) > 1) ?
		((MAX_RULES + NUM_CELLS - 1) / NUM_CELLS) : 2) - 1 : 0] clr_row,
	input  wire logic ld_en,
	input  wire logic [$clog2((((MAX_RULES + NUM_CELLS - 1) / NUM_CELLS) > 1) ?
		((MAX_RULES + NUM_CELLS - 1) / NUM_CELLS) : 2) - 1 : 0] ld_row,
	input  wire rule_t ld_rule
);

	localparam int ROWS = (MAX_RULES + NUM_CELLS - 1) / NUM_CELLS;
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int IDX_W = ROW_W + CELL_W + 1;

	logic [TOK_W:0] held_mem [ROWS];
	rule_t rule_mem [ROWS];
	logic [TOK_W:0] held_rd_q;
	rule_t rule_rd_q;

	logic vld_s1;
	logic search_s1;
	tok_t tok_s1;
	logic [IDX_W-1:0] idx_s1;

	chain_msg_t out_msg_q;
	logic [IDX_W-1:0] out_idx_q;

	logic [ROW_W-1:0] row_in;
	logic [ROW_W-1:0] row_s1;
	logic arrive_end;
	logic hv;
	tok_t ht;
	logic [TOK_W:0] wr_data;
	logic nxt_vld;
	logic nxt_search;
	tok_t nxt_tok;
	logic absorb;

	assign row_in = in_idx[ROW_W+CELL_W-1:CELL_W];
	assign row_s1 = idx_s1[ROW_W+CELL_W-1:CELL_W];
	assign arrive_end = in_msg.vld && (in_idx == n);

	always_ff @(posedge clk) begin
		if (ld_en) begin
			rule_mem[ld_row] <= ld_rule;
		end
		if (in_msg.vld) begin
			rule_rd_q <= rule_mem[row_in];
		end
	end

	always_ff @(posedge clk) begin
		if (clr_en) begin
			held_mem[clr_row] <= '0;
		end else if (vld_s1) begin
			held_mem[row_s1] <= wr_data;
		end
		if (in_msg.vld) begin
			held_rd_q <= held_mem[row_in];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_msg.vld && !arrive_end;
		end
	end

	always_ff @(posedge clk) begin
		search_s1 <= in_msg.search;
		tok_s1 <= in_msg.tok;
		idx_s1 <= in_idx;
	end

	always_comb begin
		hv = held_rd_q[TOK_W];
		ht = held_rd_q[TOK_W-1:0];
		wr_data = held_rd_q;
		nxt_vld = 1'b0;
		nxt_search = search_s1;
		nxt_tok = tok_s1;
		absorb = 1'b0;
		if (vld_s1) begin
			if (search_s1) begin
				nxt_vld = 1'b1;
				if (hv) begin
					wr_data = {1'b0, ht};
					nxt_search = 1'b0;
					nxt_tok = ht;
				end
			end else if (!hv) begin
				wr_data = {1'b1, tok_s1};
				absorb = 1'b1;
			end else if (ht == rule_rd_q.left && tok_s1 == rule_rd_q.right) begin
				wr_data = {1'b0, ht};
				nxt_vld = 1'b1;
				nxt_tok = rule_rd_q.merged;
			end else begin
				wr_data = {1'b1, tok_s1};
				nxt_vld = 1'b1;
				nxt_tok = ht;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_msg_q <= '0;
		end else begin
			out_msg_q.vld <= nxt_vld;
			out_msg_q.search <= nxt_search;
			out_msg_q.tok <= nxt_tok;
		end
	end

	always_ff @(posedge clk) begin
		out_idx_q <= idx_s1 + IDX_W'(1);
	end

	always_comb begin
		fin = '0;
		if (arrive_end) begin
			fin.vld = 1'b1;
			fin.res = 1'b1;
			fin.eos = in_msg.search;
			fin.tok = in_msg.search ? '0 : in_msg.tok;
		end else if (absorb) begin
			fin.vld = 1'b1;
		end
	end

	assign out_msg = out_msg_q;
	assign out_idx = out_idx_q;

endmodule
`default_nettype wire

### rtl/bpe_merge_tokenizer.sv
// Channel  | Dir | Fields (low bit up)
// s_       | in  | tuser: req_type; tdata: byte_value, rule_slot, rule_left, rule_right,
//          |     |   rule_token, zero fill
// m_       | out | tdata: token, zero fill; tlast: end_of_stream
// cfg_     | in  | wdata: rule_count
// One item at a time. In every stage it visits, a text or drain item first reads the
// stage row, then updates it; the walk runs over n, rule_count capped at MAX_RULES.
// After reset a clearing pass empties all stages; no item is taken meanwhile. A waiting
// result holds in a pending register while m_tready is low.
`default_nettype none
`include "assert_macros.svh"
module bpe_merge_tokenizer import bpe_pkg::*; #(
	parameter int MAX_RULES = DEFAULT_MAX_RULES
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic s_tready,
	input  wire logic [S_DATA_W-1:0] s_tdata, // byte_value, rule_slot, rule_left,
	                                          // rule_right, rule_token
	input  wire logic [REQ_W-1:0] s_tuser,    // req_type
	output logic m_tvalid,
	input  wire logic m_tready,
	output logic [M_DATA_W-1:0] m_tdata,      // token
	output logic m_tlast,
	input  wire logic cfg_we,
	input  wire logic [CFG_W-1:0] cfg_wdata
);

	localparam int ROWS = (MAX_RULES + NUM_CELLS - 1) / NUM_CELLS;
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int IDX_W = ROW_W + CELL_W + 1;
	localparam int CMP_W = (IDX_W > CFG_W) ? IDX_W : CFG_W;
	localparam int SLOT_LO = BYTE_W;
	localparam int LEFT_LO = SLOT_LO + SLOT_W;
	localparam int RIGHT_LO = LEFT_LO + TOK_W;
	localparam int MERGED_LO = RIGHT_LO + TOK_W;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_BUSY = 2'd2;

	logic [1:0] state_q;
	logic [ROW_W-1:0] clr_row_q;
	logic [CFG_W-1:0] rule_count_q;
	chain_msg_t start_q;
	logic pend_vld_q;
	tok_t pend_tok_q;
	logic pend_eos_q;
	logic m_tvalid_q;
	tok_t out_tok_q;
	logic out_eos_q;

	logic accept;
	logic [REQ_W-1:0] req;
	logic is_walk;
	logic [CMP_W-1:0] rc_ext;
	logic [CMP_W-1:0] slot_ext;
	logic [IDX_W-1:0] n_act;
	logic ld_go;
	logic [ROW_W-1:0] ld_row;
	rule_t ld_rule;
	logic move;

	chain_msg_t msg_in [NUM_CELLS];
	chain_msg_t msg_out [NUM_CELLS];
	logic [IDX_W-1:0] idx_in [NUM_CELLS];
	logic [IDX_W-1:0] idx_out [NUM_CELLS];
	fin_t fin [NUM_CELLS];
	logic [NUM_CELLS-1:0] fin_vec;
	logic [NUM_CELLS-1:0] msg_vec;
	fin_t fin_sel;
	logic fin_any;

	assign s_tready = (state_q == ST_IDLE) && !pend_vld_q;
	assign accept = s_tvalid && s_tready;
	assign req = s_tuser;
	assign is_walk = (req == REQ_TEXT) || (req == REQ_DRAIN);

	assign rc_ext = CMP_W'(rule_count_q);
	assign n_act = (rc_ext > CMP_W'(MAX_RULES)) ? IDX_W'(MAX_RULES) : IDX_W'(rc_ext);

	assign slot_ext = CMP_W'(s_tdata[SLOT_LO +: SLOT_W]);
	assign ld_go = accept && (req == REQ_LOAD) && (slot_ext < CMP_W'(MAX_RULES));
	assign ld_row = slot_ext[ROW_W+CELL_W-1:CELL_W];
	assign ld_rule.left = s_tdata[LEFT_LO +: TOK_W];
	assign ld_rule.right = s_tdata[RIGHT_LO +: TOK_W];
	assign ld_rule.merged = s_tdata[MERGED_LO +: TOK_W];

	genvar c;
	generate
		for (c = 0; c < NUM_CELLS; c++) begin : g_cell
			if (c == 0) begin : g_head
				assign msg_in[c] = start_q.vld ? start_q : msg_out[NUM_CELLS-1];
				assign idx_in[c] = start_q.vld ? '0 : idx_out[NUM_CELLS-1];
			end else begin : g_body
				assign msg_in[c] = msg_out[c-1];
				assign idx_in[c] = idx_out[c-1];
			end

			bpe_cell #(
				.MAX_RULES(MAX_RULES)
			) u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.n(n_act),
				.in_msg(msg_in[c]),
				.in_idx(idx_in[c]),
				.out_msg(msg_out[c]),
				.out_idx(idx_out[c]),
				.fin(fin[c]),
				.clr_en(state_q == ST_CLEAR),
				.clr_row(clr_row_q),
				.ld_en(ld_go && (slot_ext[CELL_W-1:0] == CELL_W'(c))),
				.ld_row(ld_row),
				.ld_rule(ld_rule)
			);

			assign fin_vec[c] = fin[c].vld;
			assign msg_vec[c] = msg_in[c].vld;
		end
	endgenerate

	always_comb begin
		fin_sel = '0;
		for (int i = 0; i < NUM_CELLS; i++) begin
			if (fin[i].vld) begin
				fin_sel = fin[i];
			end
		end
	end

	assign fin_any = |fin_vec;
	assign move = pend_vld_q && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_row_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_row_q <= clr_row_q + ROW_W'(1);
					if (clr_row_q == ROW_W'(ROWS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && is_walk) begin
						state_q <= ST_BUSY;
					end
				end
				ST_BUSY: begin
					if (fin_any) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_count_q <= '0;
		end else if (cfg_we) begin
			rule_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
		end else begin
			start_q.vld <= accept && is_walk;
			start_q.search <= (req == REQ_DRAIN);
			start_q.tok <= TOK_W'(s_tdata[BYTE_W-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (move) begin
				pend_vld_q <= 1'b0;
			end
			if (fin_any && fin_sel.res) begin
				pend_vld_q <= 1'b1;
			end
			if (move) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin_any && fin_sel.res) begin
			pend_tok_q <= fin_sel.tok;
			pend_eos_q <= fin_sel.eos;
		end
		if (move) begin
			out_tok_q <= pend_tok_q;
			out_eos_q <= pend_eos_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {{(M_DATA_W - TOK_W){1'b0}}, out_tok_q};
	assign m_tlast = out_eos_q;

	`ASSERT_CHK(a_fin_onehot, clk, arst_n, $onehot0(fin_vec), "two cells finished at once")
	`ASSERT_CHK(a_msg_onehot, clk, arst_n, $onehot0(msg_vec), "more than one message in chain")
	`ASSERT_NEVER(a_pend_overrun, clk, arst_n, fin_any && fin_sel.res && pend_vld_q,
		"result overwrote pending result")
	`ASSERT_NEVER(a_fin_idle, clk, arst_n, fin_any && (state_q != ST_BUSY),
		"chain finished outside a walk")
	`ASSERT_CHK(a_start_busy, clk, arst_n, start_q.vld |-> (state_q == ST_BUSY),
		"walk started while not busy")

endmodule
`default_nettype wire
